// ----- hdl/lcal_pkg.sv -----
// ----------------------------------------------------------------------------
// lcal_pkg
// shared types, widths and constants of the lunar date converter
// ----------------------------------------------------------------------------
package lcal_pkg;

  localparam int LcalTableYears = 100;
  localparam int LcalRomSize    = 100;
  localparam int LcalRomAw      = 7;
  localparam int LcalWordW      = 20;
  localparam int LcalModW       = 16;

  localparam int GYearW  = 12;
  localparam int GMonthW = 4;
  localparam int GDayW   = 5;
  localparam int LYearW  = 11;
  localparam int IdxW    = 4;

  localparam logic [GYearW-1:0] LcalFirstYear = 12'd1921;
  localparam logic [GYearW-1:0] LcalEndYear   = 12'd2021;
  localparam logic [LYearW-1:0] LcalBaseYear  = 11'd1921;
  localparam logic [GDayW-1:0]  LcalFirstDay  = 5'd8;
  localparam logic [16:0]       LcalDayBias   = 17'd38;
  localparam logic [IdxW-1:0]   LcalStem0     = 4'd7;
  localparam logic [IdxW-1:0]   LcalBranch0   = 4'd9;
  localparam logic [LcalWordW-1:0] LcalShortLimit = 20'd4095;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_FETCH,
    ST_WALK,
    ST_FINISH
  } lcal_state_e;

  function automatic logic [8:0] lcal_month_offset(input logic [GMonthW-1:0] m);
    logic [8:0] off;
    case (m)
      4'd1:    off = 9'd0;
      4'd2:    off = 9'd31;
      4'd3:    off = 9'd59;
      4'd4:    off = 9'd90;
      4'd5:    off = 9'd120;
      4'd6:    off = 9'd151;
      4'd7:    off = 9'd181;
      4'd8:    off = 9'd212;
      4'd9:    off = 9'd243;
      4'd10:   off = 9'd273;
      4'd11:   off = 9'd304;
      4'd12:   off = 9'd334;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

// ----- hdl/lcal_if.sv -----
// ----------------------------------------------------------------------------
// lcal interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface lcal_in_if import lcal_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [GYearW-1:0]  gregorian_year;
  logic [GMonthW-1:0] gregorian_month;
  logic [GDayW-1:0]   gregorian_day;

  modport source (output valid, gregorian_year, gregorian_month, gregorian_day,
                  input ready);
  modport sink   (input valid, gregorian_year, gregorian_month, gregorian_day,
                  output ready);
endinterface

interface lcal_out_if import lcal_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              in_range;
  logic [LYearW-1:0] lunar_year;
  logic [3:0]        lunar_month;
  logic              is_leap_month;
  logic [4:0]        lunar_day;
  logic [IdxW-1:0]   year_stem;
  logic [IdxW-1:0]   year_branch;
  logic [IdxW-1:0]   month_stem;
  logic [IdxW-1:0]   month_branch;
  logic [IdxW-1:0]   day_stem;
  logic [IdxW-1:0]   day_branch;

  modport source (output valid, in_range, lunar_year, lunar_month, is_leap_month,
                  lunar_day, year_stem, year_branch, month_stem, month_branch,
                  day_stem, day_branch,
                  input ready);
  modport sink   (input valid, in_range, lunar_year, lunar_month, is_leap_month,
                  lunar_day, year_stem, year_branch, month_stem, month_branch,
                  day_stem, day_branch,
                  output ready);
endinterface

// ----- hdl/lcal_rom.sv -----
// ----------------------------------------------------------------------------
// lcal_rom
// lunar year table, one word per year, synchronous read
// ----------------------------------------------------------------------------
module lcal_rom import lcal_pkg::*; #(
  parameter int TABLE_YEARS = LcalTableYears,
  parameter int AddrW       = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  output logic [LcalWordW-1:0] rd_data_o
);

  localparam logic [LcalWordW-1:0] YearRom [LcalRomSize] = '{
    20'd2635,   20'd333387, 20'd1701,   20'd1748,   20'd267701,
    20'd694,    20'd2391,   20'd133423, 20'd1175,   20'd396438,
    20'd3402,   20'd3749,   20'd331177, 20'd1453,   20'd694,
    20'd201326, 20'd2350,   20'd465197, 20'd3221,   20'd3402,
    20'd400202, 20'd2901,   20'd1386,   20'd267611, 20'd605,
    20'd2349,   20'd137515, 20'd2709,   20'd464533, 20'd1738,
    20'd2901,   20'd330421, 20'd1242,   20'd2651,   20'd199255,
    20'd1323,   20'd529706, 20'd3733,   20'd1706,   20'd398762,
    20'd2741,   20'd1206,   20'd267438, 20'd2647,   20'd1318,
    20'd204070, 20'd3477,   20'd461653, 20'd1386,   20'd2413,
    20'd330077, 20'd1197,   20'd2637,   20'd268877, 20'd3365,
    20'd531109, 20'd2900,   20'd2922,   20'd398042, 20'd2395,
    20'd1179,   20'd267415, 20'd2635,   20'd661067, 20'd1701,
    20'd1748,   20'd398772, 20'd2742,   20'd2391,   20'd330031,
    20'd1175,   20'd1611,   20'd200010, 20'd3749,   20'd527717,
    20'd1452,   20'd2742,   20'd332397, 20'd2350,   20'd3222,
    20'd268949, 20'd3402,   20'd3493,   20'd133973, 20'd1386,
    20'd464219, 20'd605,    20'd2349,   20'd334123, 20'd2709,
    20'd2890,   20'd267946, 20'd2773,   20'd592565, 20'd1210,
    20'd2651,   20'd395863, 20'd1323,   20'd2707,   20'd265877
  };

  logic [LcalRomAw-1:0]  rom_idx;
  logic [LcalWordW-1:0]  rd_data_q;

  assign rom_idx = LcalRomAw'(rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= YearRom[rom_idx];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/lcal_mod.sv -----
// ----------------------------------------------------------------------------
// lcal_mod
// remainder by a small constant through reciprocal multiplication, quotient then remainder registered in turn
// ----------------------------------------------------------------------------
module lcal_mod import lcal_pkg::*; #(
  parameter int W = LcalModW,
  parameter int D = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [W-1:0]  x_i,
  output logic          busy_o,
  output logic [$clog2(D)-1:0] rem_o
);

  localparam int RW = $clog2(D);
  localparam int SW = W + RW;
  localparam int MW = W + 2;
  localparam int PW = W + MW;
  localparam int QW = PW - SW;
  localparam logic [MW-1:0] Recip = MW'(((64'd1 << SW) + 64'(D - 1)) / 64'(D));

  logic [W-1:0]  x_q, x_d;
  logic [QW-1:0] q_q, q_d;
  logic [RW-1:0] r_q, r_d;
  logic [1:0]    cnt_q, cnt_d;
  logic [PW-1:0] prod;
  logic [W-1:0]  qd;

  assign busy_o = (cnt_q != 2'd0);
  // quotient from the scaled reciprocal, exact for every W-bit dividend
  assign prod   = PW'(x_q) * PW'(Recip);
  assign qd     = W'(W'(q_q) * W'(D));

  always_comb begin
    x_d   = x_q;
    q_d   = q_q;
    r_d   = r_q;
    cnt_d = cnt_q;
    if (start_i) begin
      x_d   = x_i;
      cnt_d = 2'd2;
    end else if (cnt_q == 2'd2) begin
      q_d   = prod[PW-1:SW];
      cnt_d = 2'd1;
    end else if (cnt_q == 2'd1) begin
      r_d   = RW'(x_q - qd);
      cnt_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q   <= '0;
      cnt_q <= '0;
    end else begin
      r_q   <= r_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    q_q <= q_d;
  end

  assign rem_o = r_q;

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_q < RW'(D))
    else $error("remainder out of range");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_o)
    else $error("start did not launch the unit");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o && !start_i |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("step counter skipped");

endmodule

// ----- hdl/gregorian_to_lunar_date.sv -----
// ----------------------------------------------------------------------------
// gregorian_to_lunar_date
// gregorian date to chinese lunar date with stem and branch indices
// ----------------------------------------------------------------------------
// One request at a time. A request is taken in the idle state and its day number
// is formed in the prep state; then, for each lunar year walked, the year word is
// read from the table memory in the fetch state and one month is tested per walk
// step, and the finish state registers the result. The remainder units start with
// the day number and are done before the result is registered. Out-of-range
// requests go from the idle state straight to the finish state. The next request
// is taken as soon as the result sits in the output register, even before it is
// taken; that request then waits in the finish state until the output register
// is free.
module gregorian_to_lunar_date import lcal_pkg::*; #(
  parameter int TABLE_YEARS = LcalTableYears
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lcal_in_if.sink        in_i,
  lcal_out_if.source     out_o
);

  localparam int YiW = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1;

  lcal_state_e st_q, st_d;

  logic [GYearW-1:0]  y_q, y_d;
  logic [GMonthW-1:0] m_q, m_d;
  logic [GDayW-1:0]   d_q, d_d;
  logic [6:0]         span_q, span_d;
  logic [15:0]        rem_q, rem_d;
  logic [YiW-1:0]     yi_q, yi_d;
  logic [3:0]         k_q, k_d;
  logic [IdxW-1:0]    ystem_q, ystem_d;
  logic [IdxW-1:0]    ybranch_q, ybranch_d;
  logic               rng_q, rng_d;
  logic [3:0]         month_q, month_d;
  logic               leap_q, leap_d;
  logic [4:0]         lday_q, lday_d;
  logic               ov_q, ov_d;

  logic                 in_ok;
  logic                 rom_en;
  logic [LcalWordW-1:0] word;
  logic [12:0]          mbits;
  logic [3:0]           last;
  logic [3:0]           bidx;
  logic [4:0]           mlen;
  logic [3:0]           leapm;
  logic [16:0]          dnum_w;
  logic [15:0]          dnum;
  logic [15:0]          gm_op;
  logic                 mod_start;
  logic                 b_ds, b_mb, b_ms;
  logic [3:0]           r_ds, r_db, r_ms;
  logic                 mods_done;
  logic                 load;

  assign in_ok = (in_i.gregorian_month >= 4'd1) && (in_i.gregorian_month <= 4'd12) &&
                 (in_i.gregorian_year < LcalEndYear) &&
                 ((in_i.gregorian_year > LcalFirstYear) ||
                  ((in_i.gregorian_year == LcalFirstYear) &&
                   ((in_i.gregorian_month > 4'd2) ||
                    ((in_i.gregorian_month == 4'd2) &&
                     (in_i.gregorian_day >= LcalFirstDay)))));

  // day number counted from the lunar new year 1921, which is day one
  assign dnum_w = 17'(span_q * 9'd365) + 17'(span_q >> 2) +
                  17'(lcal_month_offset(m_q)) + 17'(d_q) +
                  17'((y_q[1:0] == 2'b00) && (m_q > 4'd2)) - LcalDayBias;
  assign dnum   = dnum_w[15:0];
  assign gm_op  = 16'(span_q * 4'd12) + 16'(m_q) + 16'd4;

  lcal_rom #(
    .TABLE_YEARS (TABLE_YEARS),
    .AddrW       (YiW)
  ) u_rom (
    .clk_i     (clk_i),
    .rd_en_i   (rom_en),
    .rd_addr_i (yi_q),
    .rd_data_o (word)
  );

  lcal_mod #(.W(LcalModW), .D(10)) u_mod_ds (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .x_i     (dnum + 16'd7),
    .busy_o  (b_ds),
    .rem_o   (r_ds)
  );

  lcal_mod #(.W(LcalModW), .D(12)) u_mod_db (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .x_i     (dnum + 16'd1),
    .busy_o  (b_mb),
    .rem_o   (r_db)
  );

  lcal_mod #(.W(LcalModW), .D(10)) u_mod_ms (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .x_i     (gm_op),
    .busy_o  (b_ms),
    .rem_o   (r_ms)
  );

  assign mods_done = !b_ds && !b_mb && !b_ms;

  assign mbits = word[12:0];
  assign leapm = word[19:16];
  assign last  = (word < LcalShortLimit) ? 4'd11 : 4'd12;
  assign bidx  = last - k_q;
  assign mlen  = 5'd29 + 5'(mbits[bidx]);

  assign in_i.ready = (st_q == ST_IDLE);

  always_comb begin
    st_d      = st_q;
    y_d       = y_q;
    m_d       = m_q;
    d_d       = d_q;
    span_d    = span_q;
    rem_d     = rem_q;
    yi_d      = yi_q;
    k_d       = k_q;
    ystem_d   = ystem_q;
    ybranch_d = ybranch_q;
    rng_d     = rng_q;
    month_d   = month_q;
    leap_d    = leap_q;
    lday_d    = lday_q;
    rom_en    = 1'b0;
    mod_start = 1'b0;
    load      = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          y_d = in_i.gregorian_year;
          m_d = in_i.gregorian_month;
          d_d = in_i.gregorian_day;
          span_d = 7'(in_i.gregorian_year - LcalFirstYear);
          if (in_ok) begin
            st_d = ST_PREP;
          end else begin
            rng_d = 1'b0;
            st_d  = ST_FINISH;
          end
        end
      end
      ST_PREP: begin
        rem_d     = dnum;
        mod_start = 1'b1;
        yi_d      = '0;
        ystem_d   = LcalStem0;
        ybranch_d = LcalBranch0;
        st_d      = ST_FETCH;
      end
      ST_FETCH: begin
        rom_en = 1'b1;
        k_d    = '0;
        st_d   = ST_WALK;
      end
      ST_WALK: begin
        if (rem_q <= 16'(mlen)) begin
          rng_d  = 1'b1;
          lday_d = rem_q[4:0];
          leap_d = 1'b0;
          month_d = k_q + 4'd1;
          if (last == 4'd12) begin
            if (k_q == leapm) begin
              leap_d  = 1'b1;
              month_d = leapm;
            end else if (k_q > leapm) begin
              month_d = k_q;
            end
          end
          st_d = ST_FINISH;
        end else begin
          rem_d = rem_q - 16'(mlen);
          if (k_q == last) begin
            if (yi_q == YiW'(TABLE_YEARS - 1)) begin
              rng_d = 1'b0;
              st_d  = ST_FINISH;
            end else begin
              yi_d      = yi_q + YiW'(1);
              ystem_d   = (ystem_q == 4'd9) ? 4'd0 : ystem_q + 4'd1;
              ybranch_d = (ybranch_q == 4'd11) ? 4'd0 : ybranch_q + 4'd1;
              st_d      = ST_FETCH;
            end
          end else begin
            k_d = k_q + 4'd1;
          end
        end
      end
      ST_FINISH: begin
        if (mods_done && (!ov_q || out_o.ready)) begin
          load = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (load) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q       <= y_d;
    m_q       <= m_d;
    d_q       <= d_d;
    span_q    <= span_d;
    rem_q     <= rem_d;
    yi_q      <= yi_d;
    k_q       <= k_d;
    ystem_q   <= ystem_d;
    ybranch_q <= ybranch_d;
    rng_q     <= rng_d;
    month_q   <= month_d;
    leap_q    <= leap_d;
    lday_q    <= lday_d;
  end

  // result register, all fields cleared for dates outside the table
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_o.in_range      <= rng_q;
      out_o.lunar_year    <= rng_q ? LcalBaseYear + LYearW'(yi_q) : '0;
      out_o.lunar_month   <= rng_q ? month_q : '0;
      out_o.is_leap_month <= rng_q & leap_q;
      out_o.lunar_day     <= rng_q ? lday_q : '0;
      out_o.year_stem     <= rng_q ? ystem_q : '0;
      out_o.year_branch   <= rng_q ? ybranch_q : '0;
      out_o.month_stem    <= rng_q ? r_ms : '0;
      out_o.month_branch  <= (rng_q && (m_q != 4'd12)) ? m_q : '0;
      out_o.day_stem      <= rng_q ? r_ds : '0;
      out_o.day_branch    <= rng_q ? r_db : '0;
    end
  end

  assign out_o.valid = ov_q;

  a_walk_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_WALK) |-> (k_q <= 4'd12))
    else $error("month step beyond a thirteen-month year");

  a_good_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.in_range) |->
      (out_o.lunar_day >= 5'd1) && (out_o.lunar_day <= 5'd30) &&
      (out_o.lunar_month >= 4'd1) && (out_o.lunar_month <= 4'd12))
    else $error("lunar day or month out of range");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.in_range) |->
      (out_o.lunar_year == '0) && (out_o.lunar_day == '0) &&
      (out_o.day_stem == '0) && !out_o.is_leap_month)
    else $error("out-of-range result not cleared");

endmodule
